// ----- rtl/spsa_pkg.sv -----
// Shared constants, codes and types of the saturating point splat accumulator.
package spsa_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int COLOR_ENTRIES = 256;
  localparam int COL_W         = $clog2(MAX_WIDTH);
  localparam int ROW_W         = $clog2(MAX_HEIGHT);
  localparam int ADDR_W        = COL_W + ROW_W;
  localparam int CIDX_W        = $clog2(COLOR_ENTRIES);
  localparam int GC_W          = 40;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int DIM_W         = 11;

  localparam logic [31:0]      ORIGIN_RESET = 32'd0;
  localparam logic [23:0]      SCALE_RESET  = 24'd65536;
  localparam logic [23:0]      GAIN_RESET   = 24'd6554;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);
  localparam logic [8:0]       CHAN_MAX     = 9'd255;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_PLOT  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam logic [2:0] ST_PLOTTED = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_OUTSIDE = 3'd2;
  localparam logic [2:0] ST_LOADED  = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_SCALE    = 3'd2;
  localparam logic [2:0] REG_GAIN     = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PLOT = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [2:0]        status;
    logic [23:0]       rgb;
    logic [ADDR_W-1:0] addr;
    logic [GC_W-1:0]   gc;
  } entry_t;

endpackage

// ----- rtl/spsa_queue.sv -----
// Small queue of classified transactions between the front and the back.
module spsa_queue
  import spsa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t pop_data
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("Queue pushed while full.");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("Queue popped while empty.");
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[QPTR_W-1:0])
    else $error("Queue pointers disagree with the count.");
`endif

endmodule

// ----- rtl/spsa_front.sv -----
// Front part: configuration registers, color table, coordinate mapping and classification.
module spsa_front
  import spsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        hold,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] x_coord,
  input  logic [31:0] y_coord,
  input  logic [7:0]  color_index,
  input  logic [15:0] point_count,
  input  logic [23:0] color_value,
  output logic        push,
  output entry_t      push_data,
  input  logic        q_full
);

  logic [31:0]      origin_x;
  logic [31:0]      origin_y;
  logic [23:0]      pixel_scale;
  logic [23:0]      intensity_gain;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  logic [23:0]        ctab [COLOR_ENTRIES];
  logic [COLOR_ENTRIES-1:0] loaded;

  logic               s1_valid;
  logic [1:0]         s1_func;
  logic signed [32:0] s1_dx;
  logic signed [32:0] s1_dy;
  logic [15:0]        s1_cnt;
  logic [23:0]        s1_colv;
  logic [23:0]        s1_ctab;
  logic               s1_loaded;

  logic               s2_valid;
  logic [1:0]         s2_func;
  logic signed [41:0] s2_px;
  logic signed [41:0] s2_py;
  logic [GC_W-1:0]    s2_gc;
  logic [23:0]        s2_colv;
  logic [23:0]        s2_ctab;
  logic               s2_loaded;

  logic               advance;
  logic               accept;
  logic signed [24:0] scale_s;
  logic signed [57:0] prod_x;
  logic signed [57:0] prod_y;
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic               outside;
  entry_t             entry;

  assign advance  = !s2_valid || !q_full;
  assign in_stall = hold || !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= ORIGIN_RESET;
      origin_y       <= ORIGIN_RESET;
      pixel_scale    <= SCALE_RESET;
      intensity_gain <= GAIN_RESET;
      image_width    <= WIDTH_RESET;
      image_height   <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x       <= cfg_data;
        REG_ORIGIN_Y: origin_y       <= cfg_data;
        REG_SCALE:    pixel_scale    <= cfg_data[23:0];
        REG_GAIN:     intensity_gain <= cfg_data[23:0];
        REG_WIDTH:    image_width    <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:   image_height   <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctab <= ctab[color_index[CIDX_W-1:0]];
      if (func == FUNC_LOAD) begin
        ctab[color_index[CIDX_W-1:0]] <= color_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (accept && func == FUNC_LOAD) begin
      loaded[color_index[CIDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func   <= func;
      s1_cnt    <= point_count;
      s1_colv   <= color_value;
      s1_loaded <= loaded[color_index[CIDX_W-1:0]];
      if (func == FUNC_PLOT) begin
        s1_dx <= $signed({x_coord[31], x_coord}) - $signed({origin_x[31], origin_x});
        s1_dy <= $signed({y_coord[31], y_coord}) - $signed({origin_y[31], origin_y});
      end else begin
        s1_dx <= $signed({x_coord[31], x_coord});
        s1_dy <= $signed({y_coord[31], y_coord});
      end
    end
  end

  assign scale_s = $signed({1'b0, pixel_scale});
  assign prod_x  = s1_dx * scale_s;
  assign prod_y  = s1_dy * scale_s;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_func   <= s1_func;
      s2_gc     <= GC_W'(intensity_gain) * GC_W'(s1_cnt);
      s2_colv   <= s1_colv;
      s2_ctab   <= s1_ctab;
      s2_loaded <= s1_loaded;
      if (s1_func == FUNC_PLOT) begin
        s2_px <= prod_x[57:16];
        s2_py <= prod_y[57:16];
      end else begin
        s2_px <= {{9{s1_dx[32]}}, s1_dx};
        s2_py <= {{9{s1_dy[32]}}, s1_dy};
      end
    end
  end

  assign w_eff = (image_width > WIDTH_MAX) ? WIDTH_MAX : image_width;
  assign h_eff = (image_height > HEIGHT_MAX) ? HEIGHT_MAX : image_height;
  assign outside = s2_px[41] || s2_py[41]
                || (s2_px >= $signed({31'd0, w_eff}))
                || (s2_py >= $signed({31'd0, h_eff}));

  always_comb begin
    entry.kind   = KIND_NONE;
    entry.status = ST_OUTSIDE;
    entry.rgb    = '0;
    entry.addr   = {s2_py[ROW_W-1:0], s2_px[COL_W-1:0]};
    entry.gc     = s2_gc;
    case (s2_func)
      FUNC_LOAD: begin
        entry.status = ST_LOADED;
        entry.rgb    = s2_colv;
      end
      FUNC_PLOT: begin
        if (!s2_loaded) begin
          entry.status = ST_UNKNOWN;
        end else if (!outside) begin
          entry.kind   = KIND_PLOT;
          entry.status = ST_PLOTTED;
          entry.rgb    = s2_ctab;
        end
      end
      default: begin
        if (!outside) begin
          entry.kind   = KIND_READ;
          entry.status = ST_READ;
        end
      end
    endcase
  end

  assign push      = s2_valid && !q_full;
  assign push_data = entry;

endmodule

// ----- rtl/spsa_back.sv -----
// Back part: image memory, clearing pass, saturating update and result register.
module spsa_back
  import spsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  output logic        clearing,
  input  logic        q_empty,
  input  entry_t      q_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_FETCH  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [23:0]       image [1 << ADDR_W];
  logic [ADDR_W-1:0] clr_addr;
  entry_t            cur;
  logic [23:0]       pix;
  logic [47:0]       prod_r;
  logic [47:0]       prod_g;
  logic [47:0]       prod_b;
  logic [2:0]        res_status;
  logic [23:0]       res_rgb;
  logic [23:0]       upd_rgb;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [23:0]       mem_wdata;
  logic              emit;

  function automatic logic [7:0] sat_add(input logic [7:0] p, input logic [47:0] prod);
    logic [8:0] sum;
    begin
      sum = {1'b0, p} + {1'b0, prod[23:16]};
      if ((|prod[47:24]) || sum[8]) begin
        sat_add = CHAN_MAX[7:0];
      end else begin
        sat_add = sum[7:0];
      end
    end
  endfunction

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !q_empty;
  assign emit     = (state == S_EMIT) && (!out_valid || !out_stall);
  assign upd_rgb  = {sat_add(pix[23:16], prod_r), sat_add(pix[15:8], prod_g),
                     sat_add(pix[7:0], prod_b)};

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_addr == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (!q_empty) begin
          state_next = (q_data.kind == KIND_NONE) ? S_EMIT : S_FETCH;
        end
      end
      S_FETCH:  state_next = S_UPDATE;
      S_UPDATE: state_next = S_EMIT;
      S_EMIT:   if (emit) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur.addr;
    mem_wdata = upd_rgb;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_UPDATE && cur.kind == KIND_PLOT) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      image[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      pix <= image[cur.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur        <= q_data;
      res_status <= q_data.status;
      res_rgb    <= q_data.rgb;
    end
    if (state == S_FETCH) begin
      prod_r <= 48'(cur.rgb[23:16]) * 48'(cur.gc);
      prod_g <= 48'(cur.rgb[15:8]) * 48'(cur.gc);
      prod_b <= 48'(cur.rgb[7:0]) * 48'(cur.gc);
    end
    if (state == S_UPDATE) begin
      res_rgb <= (cur.kind == KIND_PLOT) ? upd_rgb : pix;
    end
    if (emit) begin
      status <= res_status;
      red    <= res_rgb[23:16];
      green  <= res_rgb[15:8];
      blue   <= res_rgb[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst) clearing |-> !pop)
    else $error("Transaction taken during the clearing pass.");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_READ))
    else $error("Result status out of range.");
  a_plot_writes: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && cur.kind == KIND_PLOT) |=> (state == S_EMIT && res_status == ST_PLOTTED))
    else $error("Plot update did not lead to a plotted result.");
`endif

endmodule

// ----- rtl/saturating_point_splat_accumulator.sv -----
// Top level of the saturating point splat accumulator.
//
// Channel   Direction  Handshake          Contents
// cfg       in         cfg_valid/ready    cfg_index, cfg_data
// in        in         in_valid/stall     func, coordinates, color, count
// out       out        out_valid/stall    status, red, green, blue
//
// After reset the image memory is zeroed by a clearing pass, one pixel per cycle,
// during which in_stall stays high; configuration writes are always taken.
// The front maps coordinates in two pipeline stages and queues up to four transactions.
// The back handles one transaction at a time over its single image memory: a plot
// or read passes fetch, update and emit; other transactions go straight to emit.
// Output stalls hold the result register; the queue lets the front keep accepting.
module saturating_point_splat_accumulator
  import spsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] x_coord,
  input  logic [31:0] y_coord,
  input  logic [7:0]  color_index,
  input  logic [15:0] point_count,
  input  logic [23:0] color_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  logic   clearing;
  logic   push;
  entry_t push_data;
  logic   q_full;
  logic   q_empty;
  logic   pop;
  entry_t q_data;

  assign cfg_ready = 1'b1;

  spsa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .hold        (clearing),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .color_index (color_index),
    .point_count (point_count),
    .color_value (color_value),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  spsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  spsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule
